/* hdl/pcp_pkg.sv */
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared constants, phase codes and helper functions for the capsule parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pcp_pkg;

  localparam int COUNT_BITS  = 24;
  localparam int TOKEN_BYTES = 16;
  localparam int VAL_BITS    = 62;
  localparam int PH_BITS     = 5;

  localparam logic [PH_BITS-1:0] PH_TYPE    = 5'd0;
  localparam logic [PH_BITS-1:0] PH_LEN     = 5'd1;
  localparam logic [PH_BITS-1:0] PH_CONNID  = 5'd2;
  localparam logic [PH_BITS-1:0] PH_HOSTLEN = 5'd3;
  localparam logic [PH_BITS-1:0] PH_HOST    = 5'd4;
  localparam logic [PH_BITS-1:0] PH_PORT    = 5'd5;
  localparam logic [PH_BITS-1:0] PH_DCIDLEN = 5'd6;
  localparam logic [PH_BITS-1:0] PH_DCID    = 5'd7;
  localparam logic [PH_BITS-1:0] PH_SCIDLEN = 5'd8;
  localparam logic [PH_BITS-1:0] PH_SCID    = 5'd9;
  localparam logic [PH_BITS-1:0] PH_VERSION = 5'd10;
  localparam logic [PH_BITS-1:0] PH_RFLAGS  = 5'd11;
  localparam logic [PH_BITS-1:0] PH_DIR     = 5'd12;
  localparam logic [PH_BITS-1:0] PH_ACTION  = 5'd13;
  localparam logic [PH_BITS-1:0] PH_SEQ     = 5'd14;
  localparam logic [PH_BITS-1:0] PH_RETIRE  = 5'd15;
  localparam logic [PH_BITS-1:0] PH_CIDLEN  = 5'd16;
  localparam logic [PH_BITS-1:0] PH_CID     = 5'd17;
  localparam logic [PH_BITS-1:0] PH_TOKEN   = 5'd18;
  localparam logic [PH_BITS-1:0] PH_PFLAGS  = 5'd19;
  localparam logic [PH_BITS-1:0] PH_CIDX    = 5'd20;
  localparam logic [PH_BITS-1:0] PH_PLEN    = 5'd21;
  localparam logic [PH_BITS-1:0] PH_PKT     = 5'd22;
  localparam logic [PH_BITS-1:0] PH_REASON  = 5'd23;
  localparam logic [PH_BITS-1:0] PH_DRAIN   = 5'd24;
  localparam logic [PH_BITS-1:0] PH_ECODE   = 5'd25;
  localparam logic [PH_BITS-1:0] PH_MSGLEN  = 5'd26;
  localparam logic [PH_BITS-1:0] PH_MSG     = 5'd27;
  localparam logic [PH_BITS-1:0] PH_WAIT    = 5'd28;
  localparam logic [PH_BITS-1:0] PH_DONE    = 5'd29;

  localparam logic [2:0] CL_REG   = 3'd0;
  localparam logic [2:0] CL_CIDU  = 3'd1;
  localparam logic [2:0] CL_PKT   = 3'd2;
  localparam logic [2:0] CL_DEREG = 3'd3;
  localparam logic [2:0] CL_ERR   = 3'd4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_MALFORMED  = 2'd2;
  localparam logic [1:0] ST_UNKNOWN    = 2'd3;

  localparam logic [4:0] TAG_TYPE     = 5'd0;
  localparam logic [4:0] TAG_CONNID   = 5'd1;
  localparam logic [4:0] TAG_HOSTLEN  = 5'd2;
  localparam logic [4:0] TAG_HOST     = 5'd3;
  localparam logic [4:0] TAG_PORT     = 5'd4;
  localparam logic [4:0] TAG_DCIDLEN  = 5'd5;
  localparam logic [4:0] TAG_DCID     = 5'd6;
  localparam logic [4:0] TAG_SCIDLEN  = 5'd7;
  localparam logic [4:0] TAG_SCID     = 5'd8;
  localparam logic [4:0] TAG_VERSION  = 5'd9;
  localparam logic [4:0] TAG_RFLAGS   = 5'd10;
  localparam logic [4:0] TAG_DIR      = 5'd11;
  localparam logic [4:0] TAG_ACTION   = 5'd12;
  localparam logic [4:0] TAG_SEQ      = 5'd13;
  localparam logic [4:0] TAG_RETIRE   = 5'd14;
  localparam logic [4:0] TAG_CIDLEN   = 5'd15;
  localparam logic [4:0] TAG_CID      = 5'd16;
  localparam logic [4:0] TAG_TOKEN    = 5'd17;
  localparam logic [4:0] TAG_PFLAGS   = 5'd18;
  localparam logic [4:0] TAG_CIDX     = 5'd19;
  localparam logic [4:0] TAG_PLEN     = 5'd20;
  localparam logic [4:0] TAG_PKT      = 5'd21;
  localparam logic [4:0] TAG_REASON   = 5'd22;
  localparam logic [4:0] TAG_DRAIN    = 5'd23;
  localparam logic [4:0] TAG_ECODE    = 5'd24;
  localparam logic [4:0] TAG_MSGLEN   = 5'd25;
  localparam logic [4:0] TAG_MSG      = 5'd26;
  localparam logic [4:0] TAG_STATUS   = 5'd27;

  localparam logic [2:0] REG_TYPE_REGISTER   = 3'd0;
  localparam logic [2:0] REG_TYPE_CID_UPDATE = 3'd1;
  localparam logic [2:0] REG_TYPE_PACKET     = 3'd2;
  localparam logic [2:0] REG_TYPE_DEREGISTER = 3'd3;
  localparam logic [2:0] REG_TYPE_ERROR      = 3'd4;
  localparam logic [2:0] REG_HOST_LEN_LIMIT  = 3'd5;
  localparam logic [2:0] REG_CID_LEN_LIMIT   = 3'd6;
  localparam logic [2:0] REG_MSG_LEN_LIMIT   = 3'd7;

  localparam logic [7:0] FLAG_COMPRESSED_BIT = 8'h02;

  typedef struct packed {
    logic [COUNT_BITS-1:0] bytes;
    logic [1:0]            status;
    logic [VAL_BITS-1:0]   value;
    logic [4:0]            tag;
    logic                  last;
  } res_t;

  function automatic logic is_varint(input logic [PH_BITS-1:0] p);
    return (p == PH_TYPE) || (p == PH_LEN) || (p == PH_CONNID) || (p == PH_SEQ) ||
           (p == PH_RETIRE) || (p == PH_ECODE);
  endfunction

  function automatic logic is_run(input logic [PH_BITS-1:0] p);
    return (p == PH_HOST) || (p == PH_DCID) || (p == PH_SCID) || (p == PH_CID) ||
           (p == PH_TOKEN) || (p == PH_PKT) || (p == PH_MSG);
  endfunction

  function automatic logic is_fixed(input logic [PH_BITS-1:0] p);
    return !is_varint(p) && !is_run(p) && (p != PH_WAIT) && (p != PH_DONE);
  endfunction

  // byte count loaded on entry to a phase
  function automatic logic [15:0] entry_count(input logic [PH_BITS-1:0] p);
    logic [15:0] w;
    w = 16'd0;
    if (is_fixed(p)) begin
      case (p)
        PH_PORT, PH_PLEN, PH_MSGLEN: w = 16'd2;
        PH_VERSION, PH_DRAIN:        w = 16'd4;
        default:                     w = 16'd1;
      endcase
    end
    return w;
  endfunction

  function automatic logic [4:0] run_tag(input logic [PH_BITS-1:0] p);
    logic [4:0] t;
    case (p)
      PH_HOST:  t = TAG_HOST;
      PH_DCID:  t = TAG_DCID;
      PH_SCID:  t = TAG_SCID;
      PH_CID:   t = TAG_CID;
      PH_TOKEN: t = TAG_TOKEN;
      PH_PKT:   t = TAG_PKT;
      default:  t = TAG_MSG;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

/* hdl/proxy_capsule_parser.sv */
// ----------------------------------------------------------------------------
// proxy_capsule_parser
// Byte-serial parser for one proxy capsule per buffer, with tagged results.
// ----------------------------------------------------------------------------
// One byte is taken per cycle. Each byte updates the parse state in the
// same cycle and queues zero, one or two result items (a field and/or a
// status) in a four-entry output queue; in_tready stays high while the queue
// has room for two items, so with out_tready high the input runs at one item
// per cycle except where bytes yield two results, which drain at one a cycle.
`default_nettype none

module proxy_capsule_parser
  import pcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  input  wire logic        in_tlast,    // end_of_buffer
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,   // field_tag, field_value, parse_status,
                                        // bytes_consumed, zero pad
  output logic             out_tlast,   // capsule_end
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [61:0] cfg_wdata
);

  localparam int QDEPTH = 4;

  logic [VAL_BITS-1:0] type_reg_r, type_cidu_r, type_pkt_r, type_dereg_r, type_err_r;
  logic [7:0]          host_lim_r, cid_lim_r;
  logic [15:0]         msg_lim_r;

  logic [PH_BITS-1:0]    phase_r, phase_nxt;
  logic [2:0]            cls_r, cls_nxt;
  logic [VAL_BITS-1:0]   acc_r, acc_nxt;
  logic [15:0]           left_r, left_nxt;
  logic [VAL_BITS-1:0]   decl_r, decl_nxt;
  logic [COUNT_BITS-1:0] tot_r, tot_nxt;
  logic [COUNT_BITS-1:0] vstart_r, vstart_nxt;
  logic                  comp_r, comp_nxt;
  logic                  fin_r, fin_nxt;

  logic                  in_fire;
  logic                  fld_v, sts_v, fdone;
  logic [4:0]            fld_tag;
  logic [VAL_BITS-1:0]   fld_val;
  logic [1:0]            sts_code;
  logic [COUNT_BITS-1:0] sts_bytes;
  logic [COUNT_BITS-1:0] seen_v, seen_e;
  logic [VAL_BITS-1:0]   v;
  logic [7:0]            b;

  res_t                  q_r [QDEPTH];
  logic [1:0]            wp_r, rp_r;
  logic [2:0]            cnt_r;
  logic                  pop;
  res_t                  f_item, s_item, head;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (cnt_r <= 3'(QDEPTH - 2));
  assign b         = in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_reg_r   <= 62'd0;
      type_cidu_r  <= 62'd1;
      type_pkt_r   <= 62'd2;
      type_dereg_r <= 62'd3;
      type_err_r   <= 62'd4;
      host_lim_r   <= 8'd255;
      cid_lim_r    <= 8'd20;
      msg_lim_r    <= 16'd255;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TYPE_REGISTER:   type_reg_r   <= cfg_wdata;
        REG_TYPE_CID_UPDATE: type_cidu_r  <= cfg_wdata;
        REG_TYPE_PACKET:     type_pkt_r   <= cfg_wdata;
        REG_TYPE_DEREGISTER: type_dereg_r <= cfg_wdata;
        REG_TYPE_ERROR:      type_err_r   <= cfg_wdata;
        REG_HOST_LEN_LIMIT:  host_lim_r   <= cfg_wdata[7:0];
        REG_CID_LEN_LIMIT:   cid_lim_r    <= cfg_wdata[7:0];
        REG_MSG_LEN_LIMIT:   msg_lim_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    cls_nxt    = cls_r;
    acc_nxt    = acc_r;
    left_nxt   = left_r;
    decl_nxt   = decl_r;
    tot_nxt    = tot_r;
    vstart_nxt = vstart_r;
    comp_nxt   = comp_r;
    fin_nxt    = fin_r;
    fld_v      = 1'b0;
    fld_tag    = TAG_TYPE;
    fld_val    = '0;
    sts_v      = 1'b0;
    sts_code   = ST_OK;
    sts_bytes  = '0;
    fdone      = 1'b0;
    seen_v     = '0;
    seen_e     = '0;
    v          = '0;

    if (in_fire) begin
      if (!fin_r && phase_r != PH_DONE) begin
        tot_nxt = (tot_r == {COUNT_BITS{1'b1}}) ? tot_r : tot_r + 1'b1;
        seen_v  = tot_nxt - vstart_r;
        if (phase_r == PH_WAIT) begin
          if (VAL_BITS'(seen_v) >= decl_r) begin
            sts_v     = 1'b1;
            sts_code  = ST_OK;
            sts_bytes = acc_r[COUNT_BITS-1:0];
            phase_nxt = PH_DONE;
            fin_nxt   = 1'b1;
          end
        end else if (is_varint(phase_r)) begin
          if (left_r == 16'd0) begin
            acc_nxt  = {56'd0, b[5:0]};
            left_nxt = 16'((16'd1 << b[7:6]) - 16'd1);
          end else begin
            acc_nxt  = {acc_r[VAL_BITS-9:0], b};
            left_nxt = left_r - 16'd1;
          end
          fdone = (left_nxt == 16'd0);
        end else if (is_fixed(phase_r)) begin
          acc_nxt  = {acc_r[VAL_BITS-9:0], b};
          left_nxt = (left_r != 16'd0) ? left_r - 16'd1 : left_r;
          fdone    = (left_nxt == 16'd0);
        end else if (is_run(phase_r)) begin
          fld_v    = 1'b1;
          fld_tag  = run_tag(phase_r);
          fld_val  = {54'd0, b};
          left_nxt = (left_r != 16'd0) ? left_r - 16'd1 : left_r;
          fdone    = (left_nxt == 16'd0);
        end

        if (fdone) begin
          v = acc_nxt;
          case (phase_r)
            PH_TYPE: begin
              fld_v = 1'b1; fld_tag = TAG_TYPE; fld_val = v;
              if (v == type_reg_r)        cls_nxt = CL_REG;
              else if (v == type_cidu_r)  cls_nxt = CL_CIDU;
              else if (v == type_pkt_r)   cls_nxt = CL_PKT;
              else if (v == type_dereg_r) cls_nxt = CL_DEREG;
              else if (v == type_err_r)   cls_nxt = CL_ERR;
              if (v == type_reg_r || v == type_cidu_r || v == type_pkt_r ||
                  v == type_dereg_r || v == type_err_r) begin
                phase_nxt = PH_LEN; acc_nxt = '0; left_nxt = entry_count(PH_LEN);
              end else begin
                sts_v = 1'b1; sts_code = ST_UNKNOWN; sts_bytes = tot_nxt;
              end
            end
            PH_LEN: begin
              decl_nxt = v; vstart_nxt = tot_nxt;
              phase_nxt = PH_CONNID; acc_nxt = '0; left_nxt = entry_count(PH_CONNID);
            end
            PH_CONNID: begin
              fld_v = 1'b1; fld_tag = TAG_CONNID; fld_val = v;
              case (cls_r)
                CL_REG:   phase_nxt = PH_HOSTLEN;
                CL_CIDU:  phase_nxt = PH_DIR;
                CL_PKT:   phase_nxt = PH_PFLAGS;
                CL_DEREG: phase_nxt = PH_REASON;
                default:  phase_nxt = PH_ECODE;
              endcase
              acc_nxt = '0; left_nxt = entry_count(phase_nxt);
            end
            PH_HOSTLEN: begin
              fld_v = 1'b1; fld_tag = TAG_HOSTLEN; fld_val = v;
              if (v > {54'd0, host_lim_r}) begin
                sts_v = 1'b1; sts_code = ST_MALFORMED; sts_bytes = tot_nxt;
              end else if (v == '0) begin
                phase_nxt = PH_PORT; acc_nxt = '0; left_nxt = entry_count(PH_PORT);
              end else begin
                phase_nxt = PH_HOST; left_nxt = v[15:0];
              end
            end
            PH_HOST: begin
              phase_nxt = PH_PORT; acc_nxt = '0; left_nxt = entry_count(PH_PORT);
            end
            PH_PORT: begin
              fld_v = 1'b1; fld_tag = TAG_PORT; fld_val = v;
              phase_nxt = PH_DCIDLEN; acc_nxt = '0; left_nxt = entry_count(PH_DCIDLEN);
            end
            PH_DCIDLEN: begin
              fld_v = 1'b1; fld_tag = TAG_DCIDLEN; fld_val = v;
              if (v > {54'd0, cid_lim_r}) begin
                sts_v = 1'b1; sts_code = ST_MALFORMED; sts_bytes = tot_nxt;
              end else if (v == '0) begin
                phase_nxt = PH_SCIDLEN; acc_nxt = '0; left_nxt = entry_count(PH_SCIDLEN);
              end else begin
                phase_nxt = PH_DCID; left_nxt = v[15:0];
              end
            end
            PH_DCID: begin
              phase_nxt = PH_SCIDLEN; acc_nxt = '0; left_nxt = entry_count(PH_SCIDLEN);
            end
            PH_SCIDLEN: begin
              fld_v = 1'b1; fld_tag = TAG_SCIDLEN; fld_val = v;
              if (v > {54'd0, cid_lim_r}) begin
                sts_v = 1'b1; sts_code = ST_MALFORMED; sts_bytes = tot_nxt;
              end else if (v == '0) begin
                phase_nxt = PH_VERSION; acc_nxt = '0; left_nxt = entry_count(PH_VERSION);
              end else begin
                phase_nxt = PH_SCID; left_nxt = v[15:0];
              end
            end
            PH_SCID: begin
              phase_nxt = PH_VERSION; acc_nxt = '0; left_nxt = entry_count(PH_VERSION);
            end
            PH_VERSION: begin
              fld_v = 1'b1; fld_tag = TAG_VERSION; fld_val = v;
              phase_nxt = PH_RFLAGS; acc_nxt = '0; left_nxt = entry_count(PH_RFLAGS);
            end
            PH_RFLAGS: begin
              fld_v = 1'b1; fld_tag = TAG_RFLAGS; fld_val = v;
            end
            PH_DIR: begin
              fld_v = 1'b1; fld_tag = TAG_DIR; fld_val = v;
              phase_nxt = PH_ACTION; acc_nxt = '0; left_nxt = entry_count(PH_ACTION);
            end
            PH_ACTION: begin
              fld_v = 1'b1; fld_tag = TAG_ACTION; fld_val = v;
              phase_nxt = PH_SEQ; acc_nxt = '0; left_nxt = entry_count(PH_SEQ);
            end
            PH_SEQ: begin
              fld_v = 1'b1; fld_tag = TAG_SEQ; fld_val = v;
              phase_nxt = PH_RETIRE; acc_nxt = '0; left_nxt = entry_count(PH_RETIRE);
            end
            PH_RETIRE: begin
              fld_v = 1'b1; fld_tag = TAG_RETIRE; fld_val = v;
              phase_nxt = PH_CIDLEN; acc_nxt = '0; left_nxt = entry_count(PH_CIDLEN);
            end
            PH_CIDLEN: begin
              fld_v = 1'b1; fld_tag = TAG_CIDLEN; fld_val = v;
              if (v > {54'd0, cid_lim_r}) begin
                sts_v = 1'b1; sts_code = ST_MALFORMED; sts_bytes = tot_nxt;
              end else if (v != '0) begin
                phase_nxt = PH_CID; left_nxt = v[15:0];
              end
            end
            PH_PFLAGS: begin
              fld_v = 1'b1; fld_tag = TAG_PFLAGS; fld_val = v;
              comp_nxt  = |(v[7:0] & FLAG_COMPRESSED_BIT);
              phase_nxt = comp_nxt ? PH_CIDX : PH_PLEN;
              acc_nxt = '0; left_nxt = entry_count(phase_nxt);
            end
            PH_CIDX: begin
              fld_v = 1'b1; fld_tag = TAG_CIDX; fld_val = v;
              phase_nxt = PH_PLEN; acc_nxt = '0; left_nxt = entry_count(PH_PLEN);
            end
            PH_PLEN: begin
              fld_v = 1'b1; fld_tag = TAG_PLEN; fld_val = v;
              if (v != '0) begin
                phase_nxt = PH_PKT; left_nxt = v[15:0];
              end
            end
            PH_REASON: begin
              fld_v = 1'b1; fld_tag = TAG_REASON; fld_val = v;
              phase_nxt = PH_DRAIN; acc_nxt = '0; left_nxt = entry_count(PH_DRAIN);
            end
            PH_DRAIN: begin
              fld_v = 1'b1; fld_tag = TAG_DRAIN; fld_val = v;
            end
            PH_ECODE: begin
              fld_v = 1'b1; fld_tag = TAG_ECODE; fld_val = v;
              phase_nxt = PH_MSGLEN; acc_nxt = '0; left_nxt = entry_count(PH_MSGLEN);
            end
            PH_MSGLEN: begin
              fld_v = 1'b1; fld_tag = TAG_MSGLEN; fld_val = v;
              if (v > {46'd0, msg_lim_r}) begin
                sts_v = 1'b1; sts_code = ST_MALFORMED; sts_bytes = tot_nxt;
              end else if (v != '0) begin
                phase_nxt = PH_MSG; left_nxt = v[15:0];
              end
            end
            default: ;
          endcase

          // token decision after the cid field
          if ((phase_r == PH_CIDLEN && !sts_v && v == '0) || phase_r == PH_CID) begin
            if (VAL_BITS'(seen_v) < decl_r &&
                VAL_BITS'(seen_v) + VAL_BITS'(TOKEN_BYTES) <= decl_r) begin
              phase_nxt = PH_TOKEN; left_nxt = 16'(TOKEN_BYTES);
            end else begin
              phase_nxt = PH_WAIT;
            end
          end

          // end of fields: close now or wait for the declared length
          if (phase_r == PH_RFLAGS || phase_r == PH_DRAIN || phase_r == PH_TOKEN ||
              phase_r == PH_PKT || phase_r == PH_MSG ||
              (phase_r == PH_PLEN && v == '0) ||
              (phase_r == PH_MSGLEN && !sts_v && v == '0) ||
              (phase_nxt == PH_WAIT && (phase_r == PH_CIDLEN || phase_r == PH_CID))) begin
            if (VAL_BITS'(seen_v) >= decl_r) begin
              sts_v = 1'b1; sts_code = ST_OK; sts_bytes = tot_nxt;
            end else begin
              acc_nxt = VAL_BITS'(tot_nxt); phase_nxt = PH_WAIT;
            end
          end

          if (sts_v) begin
            phase_nxt = PH_DONE; fin_nxt = 1'b1;
          end
        end
      end

      if (in_tlast) begin
        if (!fin_nxt && phase_nxt != PH_DONE) begin
          seen_e    = tot_nxt - vstart_nxt;
          sts_v     = 1'b1;
          sts_bytes = tot_nxt;
          sts_code  = (phase_nxt == PH_TYPE || phase_nxt == PH_LEN ||
                       VAL_BITS'(seen_e) < decl_nxt) ? ST_INCOMPLETE : ST_MALFORMED;
        end
        phase_nxt  = PH_TYPE;
        cls_nxt    = CL_REG;
        acc_nxt    = '0;
        left_nxt   = 16'd0;
        decl_nxt   = '0;
        tot_nxt    = '0;
        vstart_nxt = '0;
        comp_nxt   = 1'b0;
        fin_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      cls_r    <= CL_REG;
      acc_r    <= '0;
      left_r   <= 16'd0;
      decl_r   <= '0;
      tot_r    <= '0;
      vstart_r <= '0;
      comp_r   <= 1'b0;
      fin_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cls_r    <= cls_nxt;
      acc_r    <= acc_nxt;
      left_r   <= left_nxt;
      decl_r   <= decl_nxt;
      tot_r    <= tot_nxt;
      vstart_r <= vstart_nxt;
      comp_r   <= comp_nxt;
      fin_r    <= fin_nxt;
    end
  end

  // output queue
  always_comb begin
    f_item        = '0;
    f_item.tag    = fld_tag;
    f_item.value  = fld_val;
    s_item        = '0;
    s_item.tag    = TAG_STATUS;
    s_item.status = sts_code;
    s_item.bytes  = sts_bytes;
    s_item.last   = 1'b1;
  end

  assign head       = q_r[rp_r];
  assign out_tvalid = (cnt_r != 3'd0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = {3'd0, head.bytes, head.status, head.value, head.tag};
  assign out_tlast  = head.last;

  always_ff @(posedge clk) begin
    if (fld_v) q_r[wp_r] <= f_item;
    if (sts_v) q_r[wp_r + 2'(fld_v)] <= s_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_r + 2'(fld_v) + 2'(sts_v);
      rp_r  <= rp_r + 2'(pop);
      cnt_r <= cnt_r + 3'(fld_v) + 3'(sts_v) - 3'(pop);
    end
  end

`ifndef SYNTH
  a_qbound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(QDEPTH))
    else $error("output queue overflow");

  a_eob_clear : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> phase_r == PH_TYPE && !fin_r && tot_r == '0)
    else $error("parse state not cleared at end of buffer");

  a_fin_done : assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> phase_r == PH_DONE)
    else $error("finished capsule outside done phase");

  a_status_close : assert property (@(posedge clk) disable iff (!rst_n)
    sts_v && !in_tlast |=> fin_r)
    else $error("status issued without closing the capsule");
`endif

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for proxy_capsule_parser. Capsules are assembled from
// random field values under several register settings (defaults, extreme type
// codes with zero limits, duplicate codes with maximum limits, random mixes).
// Wrong declared lengths, cut-off buffers, trailing bytes and noise are mixed
// in. A scoreboard predicts the tagged items of every byte and checks each
// output item in order. Both sides idle at random, except in the final quiet run.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import pcp_pkg::*;

  typedef struct {
    logic [4:0]  tag;
    logic [61:0] value;
    logic [1:0]  status;
    logic [23:0] bytes;
    logic        cend;
  } capsule_res_t;

  class capsule_scoreboard;
    capsule_res_t expected_q[$];
    int errors;
    logic [61:0] tcode[5];
    logic [7:0]  host_lim, cid_lim;
    logic [15:0] msg_lim;
    logic [4:0]  phase;
    logic [2:0]  tclass;
    logic [63:0] acc, dlen, total, vstart;
    logic [15:0] left;
    bit          compressed, finished;

    function new();
      errors = 0;
      tcode[0] = 62'd0; tcode[1] = 62'd1; tcode[2] = 62'd2; tcode[3] = 62'd3;
      tcode[4] = 62'd4;
      host_lim = 8'd255; cid_lim = 8'd20; msg_lim = 16'd255;
      clear();
    endfunction

    function void clear();
      phase = PH_TYPE; tclass = CL_REG; acc = '0; left = 16'd0; dlen = '0;
      total = '0; vstart = '0; compressed = 1'b0; finished = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [61:0] v);
      case (idx)
        REG_TYPE_REGISTER:   tcode[0] = v;
        REG_TYPE_CID_UPDATE: tcode[1] = v;
        REG_TYPE_PACKET:     tcode[2] = v;
        REG_TYPE_DEREGISTER: tcode[3] = v;
        REG_TYPE_ERROR:      tcode[4] = v;
        REG_HOST_LEN_LIMIT:  host_lim = v[7:0];
        REG_CID_LEN_LIMIT:   cid_lim = v[7:0];
        default:             msg_lim = v[15:0];
      endcase
    endfunction

    function void emit(logic [4:0] t, logic [61:0] v, logic [1:0] s, logic [23:0] n,
                       logic e);
      capsule_res_t r;
      r.tag = t; r.value = v; r.status = s; r.bytes = n; r.cend = e;
      expected_q.push_back(r);
    endfunction

    function void field(logic [4:0] t, logic [61:0] v);
      emit(t, v, ST_OK, 24'd0, 1'b0);
    endfunction

    function void close(logic [1:0] s, logic [23:0] n);
      emit(TAG_STATUS, 62'd0, s, n, 1'b1);
      phase = PH_DONE;
      finished = 1'b1;
    endfunction

    function logic [63:0] seen();
      return total - vstart;
    endfunction

    function bit is_var(logic [4:0] p);
      return p == PH_TYPE || p == PH_LEN || p == PH_CONNID || p == PH_SEQ ||
             p == PH_RETIRE || p == PH_ECODE;
    endfunction

    // zero for anything that is not a fixed-width field
    function logic [15:0] width_of(logic [4:0] p);
      case (p)
        PH_PORT, PH_PLEN, PH_MSGLEN: return 16'd2;
        PH_VERSION, PH_DRAIN:        return 16'd4;
        PH_HOSTLEN, PH_DCIDLEN, PH_SCIDLEN, PH_RFLAGS, PH_DIR, PH_ACTION,
        PH_CIDLEN, PH_PFLAGS, PH_CIDX, PH_REASON: return 16'd1;
        default:                     return 16'd0;
      endcase
    endfunction

    function logic [4:0] tag_of_run(logic [4:0] p);
      case (p)
        PH_HOST:  return TAG_HOST;
        PH_DCID:  return TAG_DCID;
        PH_SCID:  return TAG_SCID;
        PH_CID:   return TAG_CID;
        PH_TOKEN: return TAG_TOKEN;
        PH_PKT:   return TAG_PKT;
        default:  return TAG_MSG;
      endcase
    endfunction

    function void enter(logic [4:0] p);
      phase = p;
      acc = '0;
      left = width_of(p);
    endfunction

    function void wrap_up();
      if (seen() >= dlen) begin
        close(ST_OK, total[23:0]);
      end else begin
        acc = total;
        phase = PH_WAIT;
      end
    endfunction

    function void run(logic [4:0] p, logic [61:0] len, logic [4:0] nxt);
      if (len == '0) begin
        enter(nxt);
      end else begin
        phase = p;
        left = len[15:0];
      end
    endfunction

    function void token_check();
      if (seen() < dlen && dlen - seen() >= 64'(TOKEN_BYTES))
        run(PH_TOKEN, 62'(TOKEN_BYTES), PH_DONE);
      else wrap_up();
    endfunction

    function void field_done();
      logic [61:0] v;
      v = acc[61:0];
      case (phase)
        PH_TYPE: begin
          field(TAG_TYPE, v);
          if (v == tcode[0]) tclass = CL_REG;
          else if (v == tcode[1]) tclass = CL_CIDU;
          else if (v == tcode[2]) tclass = CL_PKT;
          else if (v == tcode[3]) tclass = CL_DEREG;
          else if (v == tcode[4]) tclass = CL_ERR;
          else begin
            close(ST_UNKNOWN, total[23:0]);
            return;
          end
          enter(PH_LEN);
        end
        PH_LEN: begin
          dlen = {2'b0, v};
          vstart = total;
          enter(PH_CONNID);
        end
        PH_CONNID: begin
          field(TAG_CONNID, v);
          case (tclass)
            CL_REG:   enter(PH_HOSTLEN);
            CL_CIDU:  enter(PH_DIR);
            CL_PKT:   enter(PH_PFLAGS);
            CL_DEREG: enter(PH_REASON);
            default:  enter(PH_ECODE);
          endcase
        end
        PH_HOSTLEN: begin
          field(TAG_HOSTLEN, v);
          if (v > {54'd0, host_lim}) close(ST_MALFORMED, total[23:0]);
          else run(PH_HOST, v, PH_PORT);
        end
        PH_HOST: enter(PH_PORT);
        PH_PORT: begin field(TAG_PORT, v); enter(PH_DCIDLEN); end
        PH_DCIDLEN: begin
          field(TAG_DCIDLEN, v);
          if (v > {54'd0, cid_lim}) close(ST_MALFORMED, total[23:0]);
          else run(PH_DCID, v, PH_SCIDLEN);
        end
        PH_DCID: enter(PH_SCIDLEN);
        PH_SCIDLEN: begin
          field(TAG_SCIDLEN, v);
          if (v > {54'd0, cid_lim}) close(ST_MALFORMED, total[23:0]);
          else run(PH_SCID, v, PH_VERSION);
        end
        PH_SCID: enter(PH_VERSION);
        PH_VERSION: begin field(TAG_VERSION, v); enter(PH_RFLAGS); end
        PH_RFLAGS: begin field(TAG_RFLAGS, v); wrap_up(); end
        PH_DIR: begin field(TAG_DIR, v); enter(PH_ACTION); end
        PH_ACTION: begin field(TAG_ACTION, v); enter(PH_SEQ); end
        PH_SEQ: begin field(TAG_SEQ, v); enter(PH_RETIRE); end
        PH_RETIRE: begin field(TAG_RETIRE, v); enter(PH_CIDLEN); end
        PH_CIDLEN: begin
          field(TAG_CIDLEN, v);
          if (v > {54'd0, cid_lim}) close(ST_MALFORMED, total[23:0]);
          else if (v == '0) token_check();
          else run(PH_CID, v, PH_DONE);
        end
        PH_CID: token_check();
        PH_TOKEN: wrap_up();
        PH_PFLAGS: begin
          field(TAG_PFLAGS, v);
          compressed = (v[7:0] & FLAG_COMPRESSED_BIT) != 8'd0;
          enter(compressed ? PH_CIDX : PH_PLEN);
        end
        PH_CIDX: begin field(TAG_CIDX, v); enter(PH_PLEN); end
        PH_PLEN: begin
          field(TAG_PLEN, v);
          if (v == '0) wrap_up();
          else run(PH_PKT, v, PH_DONE);
        end
        PH_PKT: wrap_up();
        PH_REASON: begin field(TAG_REASON, v); enter(PH_DRAIN); end
        PH_DRAIN: begin field(TAG_DRAIN, v); wrap_up(); end
        PH_ECODE: begin field(TAG_ECODE, v); enter(PH_MSGLEN); end
        PH_MSGLEN: begin
          field(TAG_MSGLEN, v);
          if (v > {46'd0, msg_lim}) close(ST_MALFORMED, total[23:0]);
          else if (v == '0) wrap_up();
          else run(PH_MSG, v, PH_DONE);
        end
        PH_MSG: wrap_up();
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic eob);
      logic [1:0] s;
      if (!finished && phase != PH_DONE) begin
        if (total < 64'hFF_FFFF) total++;
        if (phase == PH_WAIT) begin
          if (seen() >= dlen) close(ST_OK, acc[23:0]);
        end else if (is_var(phase)) begin
          if (left == 16'd0) begin
            acc = {58'd0, b[5:0]};
            left = (16'd1 << b[7:6]) - 16'd1;
          end else begin
            acc = {acc[55:0], b};
            left--;
          end
          if (left == 16'd0) field_done();
        end else if (width_of(phase) != 16'd0) begin
          acc = {acc[55:0], b};
          if (left > 16'd0) left--;
          if (left == 16'd0) field_done();
        end else begin
          field(tag_of_run(phase), {54'd0, b});
          if (left > 16'd0) left--;
          if (left == 16'd0) field_done();
        end
      end
      if (eob) begin
        if (!finished && phase != PH_DONE) begin
          s = (phase == PH_TYPE || phase == PH_LEN || seen() < dlen) ? ST_INCOMPLETE
                                                                       : ST_MALFORMED;
          close(s, total[23:0]);
        end
        clear();
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [95:0] d, logic last);
      capsule_res_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected item tag %0d", d[4:0]));
        return;
      end
      e = expected_q.pop_front();
      if (d[4:0] !== e.tag || d[66:5] !== e.value || d[68:67] !== e.status ||
          d[92:69] !== e.bytes || last !== e.cend)
        report($sformatf("got tag %0d val %h st %0d n %0d end %b, want %0d %h %0d %0d %b",
                         d[4:0], d[66:5], d[68:67], d[92:69], last,
                         e.tag, e.value, e.status, e.bytes, e.cend));
    endtask
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tlast;
  logic [7:0]  in_tdata;
  logic        out_tvalid, out_tready, out_tlast;
  logic [95:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [61:0] cfg_wdata;

  capsule_scoreboard sb;
  logic [7:0] cap_q[$];
  logic [7:0] body_q[$];
  int  sent;
  bit  quiet, hold_req;
  int  hold_cnt, gap;

  proxy_capsule_parser DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  // receiver: short random stalls, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    hold_cnt = 0;
    gap = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_cnt = 150;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        out_tready <= 1'b0;
        hold_cnt--;
      end else if (gap > 0) begin
        out_tready <= 1'b0;
        gap--;
      end else begin
        out_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 3);
      end
    end
  end

  function logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function logic [61:0] rand_var();
    int w;
    w = $urandom_range(0, 62);
    return 62'(rand64() & ((64'd1 << w) - 64'd1));
  endfunction

  function void put_varint(logic [61:0] v);
    int n, nb;
    logic [63:0] w;
    n = v < 62'd64 ? 0 : v < 62'd16384 ? 1 : v < (62'd1 << 30) ? 2 : 3;
    if (n < 3 && $urandom_range(0, 3) == 0) n = $urandom_range(n, 3);
    nb = 1 << n;
    w = {2'b0, v} | (64'(n) << (8 * nb - 2));
    for (int i = nb - 1; i >= 0; i--) body_q.push_back(w[8*i +: 8]);
  endfunction

  function void put_run(int len);
    for (int i = 0; i < len; i++) body_q.push_back(8'($urandom));
  endfunction

  function int pick_len(int lim, int maxv);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, lim < 12 ? lim : 12);
    if (r < 93 || lim >= maxv) return lim < 300 ? lim : 300;
    return lim + 1;
  endfunction

  // mode 0..4 capsule class, 5 unknown type, 6 noise
  task make_buffer(int mode);
    logic [7:0] tmp[$];
    logic [61:0] dl;
    int  len, r;
    cap_q.delete();
    body_q.delete();
    if (mode == 6) begin
      put_run($urandom_range(1, 10));
    end else begin
      put_varint(rand_var());
      case (mode)
        0: begin
          len = pick_len(sb.host_lim, 255); body_q.push_back(8'(len));
          put_run(len > 300 ? 300 : len); put_run(2);
          len = pick_len(sb.cid_lim, 255); body_q.push_back(8'(len)); put_run(len);
          len = pick_len(sb.cid_lim, 255); body_q.push_back(8'(len)); put_run(len);
          put_run(5);
        end
        1: begin
          put_run(2); put_varint(rand_var()); put_varint(rand_var());
          len = pick_len(sb.cid_lim, 255); body_q.push_back(8'(len)); put_run(len);
          if ($urandom_range(0, 1)) put_run(16);
        end
        2: begin
          r = $urandom_range(0, 255);
          body_q.push_back(8'(r));
          if (r[1]) put_run(1);
          len = $urandom_range(0, 9) != 0 ? $urandom_range(0, 40) : $urandom_range(41, 300);
          body_q.push_back(8'(len >> 8)); body_q.push_back(8'(len)); put_run(len);
        end
        3: put_run(5);
        4: begin
          put_varint(rand_var());
          len = pick_len(sb.msg_lim, 65535);
          body_q.push_back(8'(len >> 8)); body_q.push_back(8'(len));
          put_run(len > 300 ? 300 : len);
        end
        default: put_run($urandom_range(0, 4));
      endcase
      tmp = body_q;
      body_q.delete();
      r = $urandom_range(0, 99);
      dl = 62'(tmp.size());
      if (r < 10) dl = dl + 62'($urandom_range(1, 20));
      else if (r < 20) dl = dl - 62'($urandom_range(0, tmp.size()));
      else if (r < 28) dl = dl + 62'd16;
      else if (r < 31) dl = rand_var();
      put_varint(mode == 5 ? rand_var() : sb.tcode[mode]);
      put_varint(dl);
      body_q = {body_q, tmp};
      if ($urandom_range(0, 9) < 3) put_run($urandom_range(1, 4));
    end
    cap_q = body_q;
    if ($urandom_range(0, 9) == 0) cap_q = cap_q[0 : $urandom_range(0, cap_q.size() - 1)];
  endtask

  task send_buffer();
    for (int i = 0; i < cap_q.size(); i++) begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      in_tdata <= cap_q[i];
      in_tlast <= (i == cap_q.size() - 1);
      in_tvalid <= 1'b1;
      do @(posedge clk); while (!in_tready);
      sb.note_byte(cap_q[i], i == cap_q.size() - 1);
      sent++;
    end
  endtask

  task drain();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task random_buffers(int nbytes);
    int r;
    nbytes += sent;
    while (sent < nbytes) begin
      r = $urandom_range(0, 99);
      make_buffer(r < 6 ? 6 : r < 12 ? 5 : $urandom_range(0, 4));
      send_buffer();
    end
  endtask

  task write_regs(logic [61:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= 3'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
      sb.set_reg(3'(i), v[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [61:0] regs[8];
    sb = new();
    sent = 0; quiet = 1'b0; hold_req = 1'b0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = 8'd0; in_tlast = 1'b0;
    cfg_we = 1'b0; cfg_addr = 3'd0; cfg_wdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    regs = '{62'd0, 62'd1, 62'd2, 62'd3, 62'd4, 62'd255, 62'd20, 62'd255};
    write_regs(regs);
    // directed: two lone type bytes, then each capsule kind, unknown type and noise
    cap_q = {8'h3F};
    send_buffer();
    cap_q = {8'h00};
    send_buffer();
    for (int m = 0; m < 7; m++) begin
      make_buffer(m);
      send_buffer();
    end
    random_buffers(200);
    drain();
    hold_req = 1'b1;
    random_buffers(200);
    drain();

    regs = '{62'h3FFF_FFFF_FFFF_FFFF, 62'd63, 62'd64, 62'd16383, rand_var(),
             62'd0, 62'd0, 62'd0};
    write_regs(regs);
    random_buffers(350);
    drain();

    regs = '{62'd7, 62'd7, 62'd7, 62'd9, 62'd9, 62'd255, 62'd255, 62'd65535};
    write_regs(regs);
    random_buffers(400);
    drain();

    for (int i = 0; i < 5; i++) regs[i] = 62'($urandom_range(0, 9));
    regs[5] = 62'($urandom_range(0, 255));
    regs[6] = 62'($urandom_range(0, 30));
    regs[7] = 62'($urandom_range(0, 400));
    write_regs(regs);
    quiet = 1'b1;
    random_buffers(450);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
